// File: rtl/dbn_pkg.sv
// ----------------------------------------------------------------------------
// dbn_pkg
// shared types, register indexes and fixed-point constants of the detection
// box decoder
// ----------------------------------------------------------------------------
package dbn_pkg;

  localparam int CLASS_COUNT = 80;
  localparam int MODEL_SIZE  = 640;

  // scaling divides by 2 * MODEL_SIZE = 5 << SCALE_SHIFT, rounding half up
  localparam logic [27:0] ROUND_BIAS  = 28'(MODEL_SIZE);
  localparam int          SCALE_SHIFT = 8;
  localparam logic [19:0] DIV5_MULT   = 20'd838861;
  localparam int          DIV5_SHIFT  = 22;

  localparam logic [15:0] CONF_THR_RST    = 16'd16384;
  localparam logic [15:0] OVERLAP_THR_RST = 16'd29491;
  localparam logic [11:0] NET_SIZE_RST    = 12'd640;

  typedef enum logic [1:0] {
    CFG_CONF_THR    = 2'd0,
    CFG_OVERLAP_THR = 2'd1,
    CFG_NET_WIDTH   = 2'd2,
    CFG_NET_HEIGHT  = 2'd3
  } dbn_cfg_e;

  typedef enum logic [3:0] {
    S_COLLECT,
    S_FLUSH,
    S_START,
    S_DRAIN,
    S_OUTER,
    S_INNER,
    S_WAIT,
    S_EMIT,
    S_E1,
    S_E2,
    S_E3,
    S_OUT,
    S_CLEAR
  } dbn_state_e;

  typedef struct packed {
    logic [13:0] center_x;
    logic [13:0] center_y;
    logic [13:0] extent_w;
    logic [13:0] extent_h;
    logic [15:0] class_score;
    logic [6:0]  class_index;
    logic        last_class;
    logic        last_proposal;
  } dbn_in_t;

  typedef struct packed {
    logic [6:0]  object_class;
    logic [15:0] confidence;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic        no_object;
    logic        overflow;
    logic        last;
  } dbn_out_t;

  // corners in 1/32 pixel: x1 = 2*cx - w, x2 = 2*cx + w
  typedef struct packed {
    logic [15:0]        score;
    logic [6:0]         cls;
    logic signed [16:0] x1;
    logic signed [16:0] y1;
    logic signed [16:0] x2;
    logic signed [16:0] y2;
  } dbn_cand_t;

  typedef struct packed {
    logic shift;
    logic wr;
    logic issue;
    logic load_res;
    logic load_empty;
    logic clear;
  } dbn_cmd_t;

  typedef struct packed {
    logic supp_sel;
    logic is_last;
    logic pipe_busy;
    logic out_busy;
  } dbn_stat_t;

endpackage

// File: rtl/dbn_if.sv
// ----------------------------------------------------------------------------
// dbn_if
// valid/ready channels for score items and detection results
// ----------------------------------------------------------------------------
interface dbn_in_if;
  logic             valid;
  logic             ready;
  dbn_pkg::dbn_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dbn_out_if;
  logic              valid;
  logic              ready;
  dbn_pkg::dbn_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/dbn_sort.sv
// ----------------------------------------------------------------------------
// dbn_sort
// running arg-max per proposal and a row of cells holding kept boxes sorted
// by confidence, one insertion per cycle
// ----------------------------------------------------------------------------
module dbn_sort #(
  parameter int  DEPTH = 64,
  localparam int CntW  = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  dbn_pkg::dbn_in_t   item_i,
  input  logic [15:0]        conf_thr_i,
  input  dbn_pkg::dbn_cmd_t  cmd_i,
  output logic [CntW-1:0]    count_o,
  output logic               overflow_o,
  output dbn_pkg::dbn_cand_t head_o
);

  logic [15:0]        best_score_q, best_score_d;
  logic [6:0]         best_class_q, best_class_d;
  logic               take;
  logic               close;
  logic               ins_v_q;
  dbn_pkg::dbn_cand_t ins_q;
  logic [16:0]        cx2, cy2, w17, h17;
  dbn_pkg::dbn_cand_t cells_q [DEPTH];
  logic [DEPTH-1:0]   stay;
  logic               full;
  logic               drop;
  logic               ins_go;
  logic [CntW-1:0]    count_q;
  logic               overflow_q;

  assign take = item_valid_i
             && (item_i.class_index < 7'(dbn_pkg::CLASS_COUNT))
             && (item_i.class_score > best_score_q);
  assign best_score_d = take ? item_i.class_score : best_score_q;
  assign best_class_d = take ? item_i.class_index : best_class_q;
  assign close = item_valid_i && (item_i.last_class || item_i.last_proposal);

  assign cx2 = {2'b00, item_i.center_x, 1'b0};
  assign cy2 = {2'b00, item_i.center_y, 1'b0};
  assign w17 = {3'b000, item_i.extent_w};
  assign h17 = {3'b000, item_i.extent_h};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_score_q <= '0;
      best_class_q <= '0;
      ins_v_q      <= 1'b0;
    end else begin
      ins_v_q <= close && (best_score_d >= conf_thr_i);
      if (cmd_i.clear || close) begin
        best_score_q <= '0;
        best_class_q <= '0;
      end else if (item_valid_i) begin
        best_score_q <= best_score_d;
        best_class_q <= best_class_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (close) begin
      ins_q.score <= best_score_d;
      ins_q.cls   <= best_class_d;
      ins_q.x1    <= $signed(cx2 - w17);
      ins_q.y1    <= $signed(cy2 - h17);
      ins_q.x2    <= $signed(cx2 + w17);
      ins_q.y2    <= $signed(cy2 + h17);
    end
  end

  assign full   = (count_q == CntW'(DEPTH));
  assign drop   = full && (ins_q.score <= cells_q[DEPTH-1].score);
  assign ins_go = ins_v_q && !drop;

  // a cell keeps its entry while it is at least as strong as the new one
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      stay[k] = (CntW'(k) < count_q) && (cells_q[k].score >= ins_q.score);
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    dbn_pkg::dbn_cand_t prev;
    dbn_pkg::dbn_cand_t next;
    logic               prev_stay;
    if (k == 0) begin : g_first
      assign prev      = ins_q;
      assign prev_stay = 1'b1;
    end else begin : g_rest
      assign prev      = cells_q[k-1];
      assign prev_stay = stay[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign next = cells_q[k];
    end else begin : g_body
      assign next = cells_q[k+1];
    end
    always_ff @(posedge clk_i) begin
      if (cmd_i.shift) begin
        cells_q[k] <= next;
      end else if (ins_go && !stay[k]) begin
        cells_q[k] <= prev_stay ? ins_q : prev;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else if (cmd_i.clear) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else if (ins_v_q) begin
      if (full) begin
        overflow_q <= 1'b1;
      end else begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  assign count_o    = count_q;
  assign overflow_o = overflow_q;
  assign head_o     = cells_q[0];

endmodule

// File: rtl/dbn_dp.sv
// ----------------------------------------------------------------------------
// dbn_dp
// candidate memory, pipelined overlap test, suppression flags and the
// scaling and clipping path to the result register
// ----------------------------------------------------------------------------
module dbn_dp #(
  parameter int  DEPTH = 64,
  localparam int CntW  = $clog2(DEPTH + 1),
  localparam int IdxW  = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dbn_pkg::dbn_cmd_t  cmd_i,
  input  logic [IdxW-1:0]    i_idx_i,
  input  logic [IdxW-1:0]    j_idx_i,
  input  logic [CntW-1:0]    count_i,
  input  dbn_pkg::dbn_cand_t head_i,
  input  logic               overflow_i,
  input  logic [15:0]        overlap_thr_i,
  input  logic [11:0]        net_w_i,
  input  logic [11:0]        net_h_i,
  output dbn_pkg::dbn_stat_t stat_o,
  dbn_out_if.source          res_o
);

  dbn_pkg::dbn_cand_t mem_q [DEPTH];
  dbn_pkg::dbn_cand_t rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[j_idx_i] <= head_i;
    end
    rd_a_q <= mem_q[i_idx_i];
    rd_b_q <= mem_q[j_idx_i];
  end

  // overlap pipeline
  logic [4:0]         pv_q;
  logic [IdxW-1:0]    tag_q [5];
  logic signed [16:0] ix1, iy1, ix2, iy2;
  logic signed [17:0] dx, dy;
  logic [16:0]        wa_s, ha_s, wb_s, hb_s;
  logic [15:0]        iw_q, ih_q, wa_q, ha_q, wb_q, hb_q;
  logic [31:0]        inter_q, aa_q, ab_q;
  logic [33:0]        uni_s;
  logic [31:0]        uni_q, inter2_q, inter3_q;
  logic [47:0]        rhs_q;
  logic               hit;
  logic [DEPTH-1:0]   supp_q;

  assign ix1  = ($signed(rd_a_q.x1) > $signed(rd_b_q.x1)) ? rd_a_q.x1 : rd_b_q.x1;
  assign iy1  = ($signed(rd_a_q.y1) > $signed(rd_b_q.y1)) ? rd_a_q.y1 : rd_b_q.y1;
  assign ix2  = ($signed(rd_a_q.x2) < $signed(rd_b_q.x2)) ? rd_a_q.x2 : rd_b_q.x2;
  assign iy2  = ($signed(rd_a_q.y2) < $signed(rd_b_q.y2)) ? rd_a_q.y2 : rd_b_q.y2;
  assign dx   = 18'(ix2) - 18'(ix1);
  assign dy   = 18'(iy2) - 18'(iy1);
  assign wa_s = rd_a_q.x2 - rd_a_q.x1;
  assign ha_s = rd_a_q.y2 - rd_a_q.y1;
  assign wb_s = rd_b_q.x2 - rd_b_q.x1;
  assign hb_s = rd_b_q.y2 - rd_b_q.y1;
  assign uni_s = {2'b00, aa_q} + {2'b00, ab_q} - {2'b00, inter_q};

  always_ff @(posedge clk_i) begin
    tag_q[0] <= j_idx_i;
    for (int k = 1; k < 5; k++) begin
      tag_q[k] <= tag_q[k-1];
    end
    iw_q     <= (dx > 18'sd0) ? dx[15:0] : 16'd0;
    ih_q     <= (dy > 18'sd0) ? dy[15:0] : 16'd0;
    wa_q     <= wa_s[15:0];
    ha_q     <= ha_s[15:0];
    wb_q     <= wb_s[15:0];
    hb_q     <= hb_s[15:0];
    inter_q  <= 32'(iw_q) * 32'(ih_q);
    aa_q     <= 32'(wa_q) * 32'(ha_q);
    ab_q     <= 32'(wb_q) * 32'(hb_q);
    uni_q    <= uni_s[33] ? 32'd0 : uni_s[31:0];
    inter2_q <= inter_q;
    rhs_q    <= 48'(overlap_thr_i) * 48'(uni_q);
    inter3_q <= inter2_q;
  end

  assign hit = pv_q[4] && ({inter3_q, 16'd0} > rhs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= '0;
      supp_q <= '0;
    end else begin
      pv_q <= {pv_q[3:0], cmd_i.issue};
      if (cmd_i.clear) begin
        supp_q <= '0;
      end else if (hit) begin
        supp_q[tag_q[4]] <= 1'b1;
      end
    end
  end

  // set when an unsuppressed entry follows the selected one
  logic more;
  always_comb begin
    more = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      if ((IdxW'(k) > i_idx_i) && (CntW'(k) < count_i) && !supp_q[k]) begin
        more = 1'b1;
      end
    end
  end

  // scaling: round_half_up(v * size / (2 * MODEL_SIZE))
  logic [14:0] ex, ey, ew, eh;
  logic [16:0] ew_s, eh_s;
  logic [27:0] px_q, py_q, pw_q, ph_q;
  logic [39:0] qx_q, qy_q, qw_q, qh_q;
  logic [17:0] rx, ry, rw, rh;
  logic [15:0] left, top;
  logic [16:0] lim_x, lim_y;
  logic [17:0] lx, ly;
  logic [17:0] wid, hgt;

  assign ex   = ($signed(rd_a_q.x1) > 17'sd0) ? rd_a_q.x1[14:0] : 15'd0;
  assign ey   = ($signed(rd_a_q.y1) > 17'sd0) ? rd_a_q.y1[14:0] : 15'd0;
  assign ew_s = rd_a_q.x2 - rd_a_q.x1;
  assign eh_s = rd_a_q.y2 - rd_a_q.y1;
  assign ew   = ew_s[14:0];
  assign eh   = eh_s[14:0];

  always_ff @(posedge clk_i) begin
    px_q <= 28'(ex) * 28'(net_w_i) + dbn_pkg::ROUND_BIAS;
    py_q <= 28'(ey) * 28'(net_h_i) + dbn_pkg::ROUND_BIAS;
    pw_q <= 28'(ew) * 28'(net_w_i) + dbn_pkg::ROUND_BIAS;
    ph_q <= 28'(eh) * 28'(net_h_i) + dbn_pkg::ROUND_BIAS;
    qx_q <= 40'(px_q[27:dbn_pkg::SCALE_SHIFT]) * 40'(dbn_pkg::DIV5_MULT);
    qy_q <= 40'(py_q[27:dbn_pkg::SCALE_SHIFT]) * 40'(dbn_pkg::DIV5_MULT);
    qw_q <= 40'(pw_q[27:dbn_pkg::SCALE_SHIFT]) * 40'(dbn_pkg::DIV5_MULT);
    qh_q <= 40'(ph_q[27:dbn_pkg::SCALE_SHIFT]) * 40'(dbn_pkg::DIV5_MULT);
  end

  assign rx    = qx_q[39:dbn_pkg::DIV5_SHIFT];
  assign ry    = qy_q[39:dbn_pkg::DIV5_SHIFT];
  assign rw    = qw_q[39:dbn_pkg::DIV5_SHIFT];
  assign rh    = qh_q[39:dbn_pkg::DIV5_SHIFT];
  assign left  = (rx > 18'd65535) ? 16'hFFFF : rx[15:0];
  assign top   = (ry > 18'd65535) ? 16'hFFFF : ry[15:0];
  assign lim_x = {1'b0, net_w_i, 4'd0} - {1'b0, left};
  assign lim_y = {1'b0, net_h_i, 4'd0} - {1'b0, top};
  assign lx    = lim_x[16] ? 18'd0 : {2'b00, lim_x[15:0]};
  assign ly    = lim_y[16] ? 18'd0 : {2'b00, lim_y[15:0]};
  assign wid   = (rw < lx) ? rw : lx;
  assign hgt   = (rh < ly) ? rh : ly;

  // result register
  logic              out_v_q;
  dbn_pkg::dbn_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.load_res || cmd_i.load_empty) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      out_q.object_class <= rd_a_q.cls;
      out_q.confidence   <= rd_a_q.score;
      out_q.left         <= left;
      out_q.top          <= top;
      out_q.box_width    <= wid[15:0];
      out_q.box_height   <= hgt[15:0];
      out_q.no_object    <= 1'b0;
      out_q.overflow     <= overflow_i;
      out_q.last         <= !more;
    end else if (cmd_i.load_empty) begin
      out_q           <= '0;
      out_q.no_object <= 1'b1;
      out_q.overflow  <= overflow_i;
      out_q.last      <= 1'b1;
    end
  end

  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;

  assign stat_o.supp_sel  = supp_q[i_idx_i];
  assign stat_o.is_last   = !more;
  assign stat_o.pipe_busy = |pv_q;
  assign stat_o.out_busy  = out_v_q;

endmodule

// File: rtl/dbn_ctrl.sv
// ----------------------------------------------------------------------------
// dbn_ctrl
// frame sequencer: collect, copy to memory, suppression loops, emission
// ----------------------------------------------------------------------------
module dbn_ctrl #(
  parameter int  DEPTH = 64,
  localparam int CntW  = $clog2(DEPTH + 1),
  localparam int IdxW  = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  input  logic [CntW-1:0]    count_i,
  input  dbn_pkg::dbn_stat_t stat_i,
  output dbn_pkg::dbn_cmd_t  cmd_o,
  output logic [IdxW-1:0]    i_idx_o,
  output logic [IdxW-1:0]    j_idx_o
);

  dbn_pkg::dbn_state_e state_q, state_d;
  logic [CntW-1:0]     i_q, i_d, j_q, j_d;
  logic                done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbn_pkg::S_COLLECT;
      i_q     <= '0;
      j_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    done_d  = done_q;
    case (state_q)
      dbn_pkg::S_COLLECT: begin
        if (in_valid_i && in_last_i) begin
          state_d = dbn_pkg::S_FLUSH;
        end
      end
      dbn_pkg::S_FLUSH: state_d = dbn_pkg::S_START;
      dbn_pkg::S_START: begin
        j_d = '0;
        if (count_i == '0) begin
          done_d  = 1'b1;
          state_d = dbn_pkg::S_OUT;
        end else begin
          state_d = dbn_pkg::S_DRAIN;
        end
      end
      dbn_pkg::S_DRAIN: begin
        j_d = j_q + 1'b1;
        if (j_q + 1'b1 == count_i) begin
          i_d     = '0;
          state_d = dbn_pkg::S_OUTER;
        end
      end
      dbn_pkg::S_OUTER: begin
        if (i_q == count_i) begin
          i_d     = '0;
          state_d = dbn_pkg::S_EMIT;
        end else if (stat_i.supp_sel) begin
          i_d = i_q + 1'b1;
        end else begin
          j_d     = i_q + 1'b1;
          state_d = dbn_pkg::S_INNER;
        end
      end
      dbn_pkg::S_INNER: begin
        if (j_q == count_i) begin
          state_d = dbn_pkg::S_WAIT;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      dbn_pkg::S_WAIT: begin
        if (!stat_i.pipe_busy) begin
          i_d     = i_q + 1'b1;
          state_d = dbn_pkg::S_OUTER;
        end
      end
      dbn_pkg::S_EMIT: begin
        if (i_q == count_i) begin
          state_d = dbn_pkg::S_CLEAR;
        end else if (stat_i.supp_sel) begin
          i_d = i_q + 1'b1;
        end else begin
          state_d = dbn_pkg::S_E1;
        end
      end
      dbn_pkg::S_E1: state_d = dbn_pkg::S_E2;
      dbn_pkg::S_E2: state_d = dbn_pkg::S_E3;
      dbn_pkg::S_E3: begin
        done_d  = stat_i.is_last;
        state_d = dbn_pkg::S_OUT;
      end
      dbn_pkg::S_OUT: begin
        if (!stat_i.out_busy) begin
          if (done_q) begin
            state_d = dbn_pkg::S_CLEAR;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = dbn_pkg::S_EMIT;
          end
        end
      end
      dbn_pkg::S_CLEAR: begin
        done_d  = 1'b0;
        state_d = dbn_pkg::S_COLLECT;
      end
      default: state_d = dbn_pkg::S_COLLECT;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dbn_pkg::S_COLLECT: in_ready_o = 1'b1;
      dbn_pkg::S_START:   cmd_o.load_empty = (count_i == '0);
      dbn_pkg::S_DRAIN: begin
        cmd_o.wr    = 1'b1;
        cmd_o.shift = 1'b1;
      end
      dbn_pkg::S_INNER:   cmd_o.issue = (j_q != count_i);
      dbn_pkg::S_E3:      cmd_o.load_res = 1'b1;
      dbn_pkg::S_CLEAR:   cmd_o.clear = 1'b1;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign i_idx_o = i_q[IdxW-1:0];
  assign j_idx_o = j_q[IdxW-1:0];

endmodule

// File: rtl/detect_box_decode_nms.sv
// ----------------------------------------------------------------------------
// detect_box_decode_nms
// detection decoder with arg-max, confidence-sorted store and greedy
// overlap suppression
// ----------------------------------------------------------------------------
// Score items are taken one per cycle while a frame is being collected: each
// cycle updates the running arg-max of the open proposal, and a closing
// item hands the kept box to a sorted row of cells that inserts one box per
// cycle. After the item that ends the frame, the block takes no item until
// the last result transaction of that frame has completed: a flush and a
// start state settle the insert, the n kept boxes are copied into a dual-read
// memory, then for every box i not yet suppressed n-1-i pair tests are
// issued one per cycle into a five-stage overlap pipeline, which drains
// before the next i. Each surviving box then passes through the scaling path
// into the result register and waits out any output stall.
// An empty frame gives a single no-object result. The store needs no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module detect_box_decode_nms #(
  parameter int CANDIDATE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dbn_in_if.sink      item_i,
  dbn_out_if.source   result_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int CntW = $clog2(CANDIDATE_DEPTH + 1);
  localparam int IdxW = $clog2(CANDIDATE_DEPTH);

  // configuration registers
  logic [15:0] conf_thr_q, overlap_thr_q;
  logic [11:0] net_w_q, net_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_thr_q    <= dbn_pkg::CONF_THR_RST;
      overlap_thr_q <= dbn_pkg::OVERLAP_THR_RST;
      net_w_q       <= dbn_pkg::NET_SIZE_RST;
      net_h_q       <= dbn_pkg::NET_SIZE_RST;
    end else if (cfg_we_i) begin
      case (dbn_pkg::dbn_cfg_e'(cfg_idx_i))
        dbn_pkg::CFG_CONF_THR:    conf_thr_q    <= cfg_data_i;
        dbn_pkg::CFG_OVERLAP_THR: overlap_thr_q <= cfg_data_i;
        dbn_pkg::CFG_NET_WIDTH:   net_w_q       <= cfg_data_i[11:0];
        dbn_pkg::CFG_NET_HEIGHT:  net_h_q       <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // control and status between sequencer and datapath
  dbn_pkg::dbn_cmd_t  cmd;
  dbn_pkg::dbn_stat_t stat;
  logic [IdxW-1:0]    i_idx, j_idx;
  logic [CntW-1:0]    count;
  logic               overflow;
  dbn_pkg::dbn_cand_t head;
  logic               in_ready;
  logic               in_take;

  assign item_i.ready = in_ready;
  // a transaction on the input only lands while collecting
  assign in_take = item_i.valid && in_ready;

  dbn_ctrl #(
    .DEPTH (CANDIDATE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_take),
    .in_last_i  (item_i.data.last_proposal),
    .in_ready_o (in_ready),
    .count_i    (count),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .i_idx_o    (i_idx),
    .j_idx_o    (j_idx)
  );

  // arg-max and sorted candidate cells
  dbn_sort #(
    .DEPTH (CANDIDATE_DEPTH)
  ) u_sort (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_take),
    .item_i       (item_i.data),
    .conf_thr_i   (conf_thr_q),
    .cmd_i        (cmd),
    .count_o      (count),
    .overflow_o   (overflow),
    .head_o       (head)
  );

  // memory, overlap pipeline, scaling and result register
  dbn_dp #(
    .DEPTH (CANDIDATE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .i_idx_i       (i_idx),
    .j_idx_i       (j_idx),
    .count_i       (count),
    .head_i        (head),
    .overflow_i    (overflow),
    .overlap_thr_i (overlap_thr_q),
    .net_w_i       (net_w_q),
    .net_h_i       (net_h_q),
    .stat_o        (stat),
    .res_o         (result_o)
  );

endmodule

// File: rtl/dbn_checker.sv
// ----------------------------------------------------------------------------
// dbn_checker
// port-level checks of frame sequencing on the decoder
// ----------------------------------------------------------------------------
module dbn_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_last_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input dbn_pkg::dbn_out_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input open while results pending");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.no_object |-> out_data_i.last)
    else $error("no-object result not last");

  a_frame_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input still open after frame end");

  a_result_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_data_i.last |=> !out_valid_i)
    else $error("result after last of frame");

endmodule

bind detect_box_decode_nms dbn_checker u_dbn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .in_last_i   (item_i.data.last_proposal),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);
